[rtl/core/sgt_pkg.sv]
// Shared types and constants of the segment gather table.
package sgt_pkg;

  typedef struct packed {
    logic [1:0]  src;
    logic [15:0] off;
    logic [15:0] len;
  } desc_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_MERGE
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    desc_t       wdata;
    logic [15:0] addlen;
  } cell_ctrl_t;

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_APPEND = 3'd1;
  localparam logic [2:0] MODE_ENC    = 3'd2;
  localparam logic [2:0] MODE_INSERT = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_TABLE     = 3'd2;
  localparam logic [2:0] ST_ENC_FULL  = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  localparam logic [1:0] SRC_ENCODED = 2'd0;

  localparam logic [15:0] DER_SHORT_LIMIT = 16'h0080;
  localparam logic [15:0] DER_ONE_BYTE_MAX = 16'h00FF;
  localparam logic [7:0]  DER_LEN_81 = 8'h81;
  localparam logic [7:0]  DER_LEN_82 = 8'h82;

endpackage

[rtl/core/segment_gather_table_top.sv]
// Top level of the segment gather table: controller plus descriptor ring.
//
// Clear, append, append-encoded and insert-header each take the item and
// register its single result at the next edge. A read range walks the
// descriptor ring, which rotates by one cell per cycle while the output side
// does not stall, so that cell 0 always presents the next descriptor; the walk
// ends when the ring has made a full turn back to its home position, and it
// pauses while a piece is waiting on a stalled output. A read that is out of
// range or of zero length gives its one result at once. A new transaction is
// taken while the block is not walking and the output register is free or
// being emptied. Insert shifts the tail of the table up by one cell, each
// tail cell loading its lower neighbor. Descriptor cells hold no reset; only
// entries below the segment count are ever used.
module segment_gather_table_top #(
  parameter int MAX_SEGMENTS  = 32,
  parameter int ENCODED_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [1:0]  source_kind_i,
  input  logic [15:0] position_i,
  input  logic [15:0] length_i,
  input  logic [4:0]  slot_index_i,
  input  logic [7:0]  tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  piece_source_o,
  output logic [15:0] piece_offset_o,
  output logic [15:0] piece_length_o,
  output logic [15:0] dest_offset_o,
  output logic [31:0] header_bytes_o,
  output logic [15:0] stream_total_o,
  output logic        last_o
);
  import sgt_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int RW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int FW = $clog2(ENCODED_BYTES + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e      state_q;
  logic [CW-1:0] count_q;
  logic [15:0] slen_q;
  logic [FW-1:0] fill_q;
  desc_t       last_q;
  logic [RW-1:0] rot_q;
  logic [16:0] start_q;
  logic [15:0] rpos_q;
  logic [16:0] rend_q;
  logic        done_q;

  logic        ov_q;
  logic [2:0]  status_q;
  logic [1:0]  psrc_q;
  logic [15:0] poff_q;
  logic [15:0] plen_q;
  logic [15:0] dst_q;
  logic [31:0] hdr_q;
  logic        last_flag_q;

  cell_ctrl_t  ctrl;
  logic [CW-1:0] cidx;
  desc_t       cells [MAX_SEGMENTS];

  logic        can_out, accept;
  assign can_out    = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && can_out;
  assign accept     = in_valid_i && in_ready_o;

  // request decode
  logic        full;
  logic [16:0] fill_plus_len, fill_plus_h, last_end;
  logic [15:0] hlen;
  logic [31:0] hdr;
  logic        merge, bad_idx;
  logic [CW-1:0] slot;
  logic [16:0] read_end;

  assign full          = count_q >= CW'(MAX_SEGMENTS);
  assign fill_plus_len = 17'(fill_q) + 17'(length_i);
  assign last_end      = 17'(last_q.off) + 17'(last_q.len);
  assign merge         = (count_q != '0) && (last_q.src == SRC_ENCODED) &&
                         (last_end == 17'(fill_q));
  assign slot          = CW'(slot_index_i);
  assign bad_idx       = 32'(slot_index_i) > 32'(count_q);
  assign read_end      = 17'(position_i) + 17'(length_i);

  always_comb begin
    if (length_i < DER_SHORT_LIMIT) begin
      hlen = 16'd2;
      hdr  = {tag_i, length_i[7:0], 16'h0000};
    end else if (length_i <= DER_ONE_BYTE_MAX) begin
      hlen = 16'd3;
      hdr  = {tag_i, DER_LEN_81, length_i[7:0], 8'h00};
    end else begin
      hlen = 16'd4;
      hdr  = {tag_i, DER_LEN_82, length_i};
    end
  end
  assign fill_plus_h = 17'(fill_q) + 17'(hlen);

  // walk step, head descriptor sits in cell 0
  desc_t       head;
  logic        active, hit;
  logic [16:0] seg_end, cs, ce;
  assign head    = cells[0];
  assign active  = (32'(rot_q) < 32'(count_q)) && !done_q;
  assign seg_end = start_q + 17'(head.len);
  assign hit     = active && (seg_end > 17'(rpos_q)) && (start_q < rend_q);
  assign cs      = (start_q > 17'(rpos_q)) ? start_q : 17'(rpos_q);
  assign ce      = (seg_end < rend_q) ? seg_end : rend_q;

  // cell control
  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.wdata  = '0;
    ctrl.addlen = length_i;
    cidx        = count_q;
    if (accept) begin
      case (mode_i)
        MODE_APPEND: begin
          if (!full) begin
            ctrl.op    = CELL_INS;
            ctrl.wdata = '{src: source_kind_i, off: position_i, len: length_i};
          end
        end
        MODE_ENC: begin
          if (fill_plus_len <= 17'(ENCODED_BYTES)) begin
            if (merge) begin
              ctrl.op = CELL_MERGE;
              cidx    = count_q - CW'(1);
            end else if (!full) begin
              ctrl.op    = CELL_INS;
              ctrl.wdata = '{src: SRC_ENCODED, off: 16'(fill_q), len: length_i};
            end
          end
        end
        MODE_INSERT: begin
          cidx = slot;
          if (!bad_idx && !full && fill_plus_h <= 17'(ENCODED_BYTES)) begin
            ctrl.op    = CELL_INS;
            ctrl.wdata = '{src: SRC_ENCODED, off: 16'(fill_q), len: hlen};
          end
        end
        default: ctrl.op = CELL_HOLD;
      endcase
    end else if (state_q == S_WALK && can_out) begin
      ctrl.op = CELL_ROT;
    end
  end

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    sgt_cell #(.CW(CW)) u_cell (
      .clk_i    (clk_i),
      .my_idx_i (CW'(i)),
      .idx_i    (cidx),
      .count_i  (count_q),
      .ctrl_i   (ctrl),
      .next_i   (cells[(i + 1) % MAX_SEGMENTS]),
      .prev_i   (cells[(i == 0) ? 0 : i - 1]),
      .desc_o   (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      slen_q  <= '0;
      fill_q  <= '0;
      ov_q    <= 1'b0;
      rot_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      if (out_ready_i) ov_q <= 1'b0;
      if (accept) begin
        ov_q        <= 1'b1;
        status_q    <= ST_OK;
        psrc_q      <= '0;
        poff_q      <= '0;
        plen_q      <= '0;
        dst_q       <= '0;
        hdr_q       <= '0;
        last_flag_q <= 1'b1;
        case (mode_i)
          MODE_CLEAR: begin
            count_q <= '0;
            slen_q  <= '0;
            fill_q  <= '0;
          end
          MODE_APPEND: begin
            if (full) begin
              status_q <= ST_TABLE;
            end else begin
              count_q <= count_q + CW'(1);
              slen_q  <= slen_q + length_i;
              last_q  <= '{src: source_kind_i, off: position_i, len: length_i};
              psrc_q  <= source_kind_i;
              poff_q  <= position_i;
              plen_q  <= length_i;
            end
          end
          MODE_ENC: begin
            if (fill_plus_len > 17'(ENCODED_BYTES)) begin
              status_q <= ST_ENC_FULL;
            end else if (!merge && full) begin
              status_q <= ST_TABLE;
            end else begin
              fill_q <= FW'(fill_plus_len);
              slen_q <= slen_q + length_i;
              if (merge) begin
                last_q.len <= last_q.len + length_i;
              end else begin
                count_q <= count_q + CW'(1);
                last_q  <= '{src: SRC_ENCODED, off: 16'(fill_q), len: length_i};
              end
              poff_q <= 16'(fill_q);
              plen_q <= length_i;
            end
          end
          MODE_INSERT: begin
            if (bad_idx) begin
              status_q <= ST_BAD_INDEX;
            end else if (full) begin
              status_q <= ST_TABLE;
            end else if (fill_plus_h > 17'(ENCODED_BYTES)) begin
              status_q <= ST_ENC_FULL;
            end else begin
              fill_q  <= FW'(fill_plus_h);
              count_q <= count_q + CW'(1);
              slen_q  <= slen_q + hlen;
              if (slot == count_q) begin
                last_q <= '{src: SRC_ENCODED, off: 16'(fill_q), len: hlen};
              end
              poff_q <= 16'(fill_q);
              plen_q <= hlen;
              hdr_q  <= hdr;
            end
          end
          MODE_READ: begin
            if (read_end > 17'(slen_q)) begin
              status_q <= ST_RANGE;
            end else if (length_i != '0) begin
              // pieces come from the walk
              ov_q    <= 1'b0;
              state_q <= S_WALK;
              rot_q   <= '0;
              start_q <= '0;
              done_q  <= 1'b0;
              rpos_q  <= position_i;
              rend_q  <= read_end;
            end
          end
          default: status_q <= ST_OK;
        endcase
      end else if (state_q == S_WALK && can_out) begin
        if (active) start_q <= seg_end;
        if (hit) begin
          ov_q        <= 1'b1;
          status_q    <= ST_OK;
          psrc_q      <= head.src;
          poff_q      <= head.off + 16'(cs - start_q);
          plen_q      <= 16'(ce - cs);
          dst_q       <= 16'(cs - 17'(rpos_q));
          hdr_q       <= '0;
          last_flag_q <= (ce == rend_q);
          if (ce == rend_q) done_q <= 1'b1;
        end
        rot_q <= rot_q + RW'(1);
        if (32'(rot_q) == MAX_SEGMENTS - 1) state_q <= S_IDLE;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign status_o       = status_q;
  assign piece_source_o = psrc_q;
  assign piece_offset_o = poff_q;
  assign piece_length_o = plen_q;
  assign dest_offset_o  = dst_q;
  assign header_bytes_o = hdr_q;
  assign stream_total_o = slen_q;
  assign last_o         = last_flag_q;

endmodule

[rtl/core/sgt_cell.sv]
// One descriptor cell of the segment table ring.
module sgt_cell #(
  parameter int CW = 6
) (
  input  logic               clk_i,
  input  logic [CW-1:0]      my_idx_i,
  input  logic [CW-1:0]      idx_i,
  input  logic [CW-1:0]      count_i,
  input  sgt_pkg::cell_ctrl_t ctrl_i,
  input  sgt_pkg::desc_t     next_i,
  input  sgt_pkg::desc_t     prev_i,
  output sgt_pkg::desc_t     desc_o
);
  import sgt_pkg::*;

  desc_t desc_q, desc_d;

  always_comb begin
    desc_d = desc_q;
    case (ctrl_i.op)
      CELL_ROT: desc_d = next_i;
      CELL_INS: begin
        if (my_idx_i == idx_i) begin
          desc_d = ctrl_i.wdata;
        end else if (my_idx_i > idx_i && my_idx_i <= count_i) begin
          desc_d = prev_i;
        end
      end
      CELL_MERGE: begin
        if (my_idx_i == idx_i) desc_d.len = desc_q.len + ctrl_i.addlen;
      end
      default: desc_d = desc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

  assign desc_o = desc_q;

endmodule

[tb/tb_segment_gather_table_top.sv]
// Self-checking testbench for segment_gather_table_top: random traffic, built-in table predictor.
`timescale 1ns / 100ps

module tb_segment_gather_table_top;
  import sgt_pkg::*;

  localparam int MAX_SEG   = 32;
  localparam int ENC_BYTES = 256;
  localparam int CYCLE_LIMIT = 400000;

  // One input transaction
  typedef struct {
    logic [2:0]  mode;
    logic [1:0]  kind;
    logic [15:0] pos;
    logic [15:0] len;
    logic [4:0]  idx;
    logic [7:0]  tag;
  } table_op_t;

  // One result transaction
  typedef struct {
    logic [2:0]  status;
    logic [1:0]  src;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] dst;
    logic [31:0] hdr;
    logic [15:0] total;
    logic        last;
  } piece_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  mode_i = '0;
  logic [1:0]  source_kind_i = '0;
  logic [15:0] position_i = '0;
  logic [15:0] length_i = '0;
  logic [4:0]  slot_index_i = '0;
  logic [7:0]  tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [1:0]  piece_source_o;
  logic [15:0] piece_offset_o;
  logic [15:0] piece_length_o;
  logic [15:0] dest_offset_o;
  logic [31:0] header_bytes_o;
  logic [15:0] stream_total_o;
  logic        last_o;

  segment_gather_table_top #(
    .MAX_SEGMENTS (MAX_SEG),
    .ENCODED_BYTES(ENC_BYTES)
  ) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending stimulus and expected pieces
  table_op_t op_queue[$];
  piece_t    piece_queue[$];
  int        err_count = 0;
  int        cycle_count = 0;
  int        in_gap = 0;
  int        out_stall = 0;

  // Shadow of the descriptor table
  logic [1:0]  tbl_src[MAX_SEG];
  logic [15:0] tbl_off[MAX_SEG];
  logic [15:0] tbl_len[MAX_SEG];
  int unsigned tbl_count = 0;
  logic [15:0] tbl_total = '0;
  int unsigned enc_fill = 0;

  // Bit 6 of the cycle counter flips between randomly gapped and full-rate stretches.
  wire full_rate = cycle_count[6];

  function automatic piece_t mk_piece(logic [2:0] st, logic [1:0] src, logic [15:0] off,
                                      logic [15:0] len, logic [15:0] dst, logic [31:0] hdr,
                                      logic last);
    piece_t p;
    p.status = st; p.src = src; p.off = off; p.len = len;
    p.dst = dst; p.hdr = hdr; p.total = tbl_total; p.last = last;
    return p;
  endfunction

  // Apply one transaction to the shadow table, queueing the pieces it yields.
  task automatic apply_table_op(table_op_t t);
    int unsigned pos, len, start, copied, end_req, seg_end, cs, ce, hlen, base;
    logic [31:0] hdr;
    logic        merge;
    piece_t      rd[$];
    pos = t.pos; len = t.len;
    case (t.mode)
      MODE_CLEAR: begin
        tbl_count = 0; tbl_total = '0; enc_fill = 0;
        piece_queue.push_back(mk_piece(ST_OK, 0, 0, 0, 0, 0, 1));
      end
      MODE_APPEND: begin
        if (tbl_count >= MAX_SEG) begin
          piece_queue.push_back(mk_piece(ST_TABLE, 0, 0, 0, 0, 0, 1));
        end else begin
          tbl_src[tbl_count] = t.kind; tbl_off[tbl_count] = t.pos; tbl_len[tbl_count] = t.len;
          tbl_count++;
          tbl_total = tbl_total + t.len;
          piece_queue.push_back(mk_piece(ST_OK, t.kind, t.pos, t.len, 0, 0, 1));
        end
      end
      MODE_ENC: begin
        base = enc_fill;
        merge = 1'b0;
        if (enc_fill + len > ENC_BYTES) begin
          piece_queue.push_back(mk_piece(ST_ENC_FULL, 0, 0, 0, 0, 0, 1));
        end else begin
          if (tbl_count > 0)
            merge = (tbl_src[tbl_count-1] == SRC_ENCODED) &&
                    (int'(tbl_off[tbl_count-1]) + int'(tbl_len[tbl_count-1]) == base);
          if (!merge && tbl_count >= MAX_SEG) begin
            piece_queue.push_back(mk_piece(ST_TABLE, 0, 0, 0, 0, 0, 1));
          end else begin
            enc_fill += len;
            if (merge) begin
              tbl_len[tbl_count-1] = tbl_len[tbl_count-1] + t.len;
            end else begin
              tbl_src[tbl_count] = SRC_ENCODED; tbl_off[tbl_count] = 16'(base);
              tbl_len[tbl_count] = t.len;
              tbl_count++;
            end
            tbl_total = tbl_total + t.len;
            piece_queue.push_back(mk_piece(ST_OK, 0, 16'(base), t.len, 0, 0, 1));
          end
        end
      end
      MODE_INSERT: begin
        if (len < 'h80) begin
          hlen = 2; hdr = {t.tag, t.len[7:0], 16'h0};
        end else if (len <= 'hFF) begin
          hlen = 3; hdr = {t.tag, DER_LEN_81, t.len[7:0], 8'h0};
        end else begin
          hlen = 4; hdr = {t.tag, DER_LEN_82, t.len};
        end
        if (t.idx > tbl_count) begin
          piece_queue.push_back(mk_piece(ST_BAD_INDEX, 0, 0, 0, 0, 0, 1));
        end else if (tbl_count >= MAX_SEG) begin
          piece_queue.push_back(mk_piece(ST_TABLE, 0, 0, 0, 0, 0, 1));
        end else if (enc_fill + hlen > ENC_BYTES) begin
          piece_queue.push_back(mk_piece(ST_ENC_FULL, 0, 0, 0, 0, 0, 1));
        end else begin
          base = enc_fill;
          enc_fill += hlen;
          for (int i = tbl_count; i > t.idx; i--) begin
            tbl_src[i] = tbl_src[i-1]; tbl_off[i] = tbl_off[i-1]; tbl_len[i] = tbl_len[i-1];
          end
          tbl_src[t.idx] = SRC_ENCODED; tbl_off[t.idx] = 16'(base);
          tbl_len[t.idx] = 16'(hlen);
          tbl_count++;
          tbl_total = tbl_total + 16'(hlen);
          piece_queue.push_back(mk_piece(ST_OK, 0, 16'(base), 16'(hlen), 0, hdr, 1));
        end
      end
      MODE_READ: begin
        start = 0; copied = 0; end_req = pos + len;
        if (pos > tbl_total || len > tbl_total - pos) begin
          piece_queue.push_back(mk_piece(ST_RANGE, 0, 0, 0, 0, 0, 1));
        end else begin
          for (int i = 0; i < tbl_count && copied < len; i++) begin
            seg_end = start + tbl_len[i];
            if (seg_end > pos && start < end_req) begin
              cs = (start > pos) ? start : pos;
              ce = (seg_end < end_req) ? seg_end : end_req;
              rd.push_back(mk_piece(ST_OK, tbl_src[i], 16'(tbl_off[i] + (cs - start)),
                                    16'(ce - cs), 16'(copied), 0, 0));
              copied += ce - cs;
            end
            start = seg_end;
          end
          if (rd.size() == 0 || copied != len) begin
            piece_queue.push_back(mk_piece((copied == len) ? ST_OK : ST_RANGE, 0, 0, 0, 0, 0, 1));
          end else begin
            rd[rd.size()-1].last = 1'b1;
            foreach (rd[k]) piece_queue.push_back(rd[k]);
          end
        end
      end
      default: piece_queue.push_back(mk_piece(ST_OK, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  function automatic table_op_t mk_op(logic [2:0] m, logic [1:0] k, logic [15:0] p,
                                      logic [15:0] l, logic [4:0] x, logic [7:0] g);
    table_op_t t;
    t.mode = m; t.kind = k; t.pos = p; t.len = l; t.idx = x; t.tag = g;
    return t;
  endfunction

  function automatic logic [15:0] rand_len();
    return ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
  endfunction

  // Driver: one transaction at a time from op_queue, random gap between them.
  always @(posedge clk_i or negedge rst_ni) begin
    table_op_t t;
    int g;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (in_valid_i && in_ready_o) begin
        apply_table_op(mk_op(mode_i, source_kind_i, position_i, length_i, slot_index_i, tag_i));
        g = full_rate ? 0 : $urandom_range(0, 9);
        if (g == 0 && op_queue.size() > 0) begin
          t = op_queue.pop_front();
          mode_i <= t.mode; source_kind_i <= t.kind; position_i <= t.pos;
          length_i <= t.len; slot_index_i <= t.idx; tag_i <= t.tag;
        end else begin
          in_valid_i <= 1'b0;
          in_gap <= (g == 0) ? 0 : g - 1;
        end
      end else if (!in_valid_i) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (op_queue.size() > 0) begin
          t = op_queue.pop_front();
          mode_i <= t.mode; source_kind_i <= t.kind; position_i <= t.pos;
          length_i <= t.len; slot_index_i <= t.idx; tag_i <= t.tag;
          in_valid_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expected piece, random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    piece_t e;
    int g;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (piece_queue.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10) $display("unexpected result: status %0d", status_o);
        end else begin
          e = piece_queue.pop_front();
          if (status_o !== e.status || piece_source_o !== e.src || piece_offset_o !== e.off ||
              piece_length_o !== e.len || dest_offset_o !== e.dst ||
              header_bytes_o !== e.hdr || stream_total_o !== e.total || last_o !== e.last) begin
            err_count <= err_count + 1;
            if (err_count < 10) begin
              $display("mismatch exp st %0d src %0d off %h len %h dst %h hdr %h tot %h last %b",
                       e.status, e.src, e.off, e.len, e.dst, e.hdr, e.total, e.last);
              $display("         got st %0d src %0d off %h len %h dst %h hdr %h tot %h last %b",
                       status_o, piece_source_o, piece_offset_o, piece_length_o,
                       dest_offset_o, header_bytes_o, stream_total_o, last_o);
            end
          end
        end
        g = full_rate ? 0 : $urandom_range(0, 9);
        if (g != 0) begin
          out_ready_i <= 1'b0;
          out_stall <= g - 1;
        end
      end else if (!out_ready_i) begin
        if (out_stall > 0) out_stall <= out_stall - 1;
        else out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_segment_gather_table_top: errors");
      $finish;
    end
  end

  initial begin
    int r;
    // Directed: header length boundaries, error cases, odd modes and kinds.
    op_queue.push_back(mk_op(MODE_CLEAR, 0, 0, 0, 0, 0));
    op_queue.push_back(mk_op(MODE_READ, 0, 0, 0, 0, 0));          // zero-length, empty table
    op_queue.push_back(mk_op(MODE_READ, 0, 1, 0, 0, 0));          // start past end
    op_queue.push_back(mk_op(MODE_APPEND, 2'd3, 16'hFFFF, 16'd10, 0, 0));
    op_queue.push_back(mk_op(MODE_ENC, 0, 0, 16'd5, 0, 0));
    op_queue.push_back(mk_op(MODE_ENC, 0, 0, 16'd7, 0, 0));       // merges
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'h007F, 5'd0, 8'hFF));
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'h0080, 5'd1, 8'h30));
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'h00FF, 5'd5, 8'h00));
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'h0100, 5'd5, 8'hA5));
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'hFFFF, 5'd31, 8'h5A)); // bad index
    op_queue.push_back(mk_op(MODE_ENC, 0, 0, 16'd300, 0, 0));     // encoded area full
    op_queue.push_back(mk_op(MODE_READ, 0, 0, 16'd33, 0, 0));     // longer than the stream
    op_queue.push_back(mk_op(MODE_READ, 0, 16'd3, 16'd20, 0, 0));
    op_queue.push_back(mk_op(MODE_READ, 0, 16'd10, 16'hFFFF, 0, 0)); // runs past end
    op_queue.push_back(mk_op(3'd5, 2'd3, 16'hFFFF, 16'hFFFF, 5'd31, 8'hFF));
    op_queue.push_back(mk_op(3'd6, 0, 0, 0, 0, 0));
    op_queue.push_back(mk_op(3'd7, 0, 0, 0, 0, 0));
    op_queue.push_back(mk_op(MODE_APPEND, 2'd1, 16'h1234, 16'hFFF0, 0, 0)); // total wraps
    op_queue.push_back(mk_op(MODE_READ, 0, 0, 16'd30, 0, 0));
    op_queue.push_back(mk_op(MODE_ENC, 0, 0, 16'd210, 0, 0));
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'd1, 5'd0, 8'h04)); // header in slot 0, still fits the area
    op_queue.push_back(mk_op(MODE_CLEAR, 0, 0, 0, 0, 0));
    // Fill the table to capacity, then hit every table-full path.
    for (int i = 0; i < MAX_SEG; i++)
      op_queue.push_back(mk_op(MODE_APPEND, 2'($urandom_range(1, 3)), 16'($urandom),
                               16'($urandom_range(1, 9)), 0, 0));
    op_queue.push_back(mk_op(MODE_APPEND, 2'd1, 0, 16'd1, 0, 0));
    op_queue.push_back(mk_op(MODE_ENC, 0, 0, 16'd4, 0, 0));
    op_queue.push_back(mk_op(MODE_INSERT, 0, 0, 16'd4, 5'd3, 8'h02));
    op_queue.push_back(mk_op(MODE_READ, 0, 16'd2, 16'd100, 0, 0));
    op_queue.push_back(mk_op(MODE_CLEAR, 0, 0, 0, 0, 0));
    // Random: mostly table builds and reads over short streams.
    for (int i = 0; i < 40; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        op_queue.push_back(mk_op(MODE_CLEAR, 2'($urandom), 16'($urandom), 16'($urandom),
                                 5'($urandom), 8'($urandom)));
      else if (r < 30)
        op_queue.push_back(mk_op(MODE_APPEND, 2'($urandom), 16'($urandom), rand_len(),
                                 5'($urandom), 8'($urandom)));
      else if (r < 48)
        op_queue.push_back(mk_op(MODE_ENC, 2'($urandom), 16'($urandom),
                                 16'($urandom_range(0, 24)), 5'($urandom), 8'($urandom)));
      else if (r < 63)
        op_queue.push_back(mk_op(MODE_INSERT, 2'($urandom), 16'($urandom),
                                 ($urandom_range(0, 1) ? 16'($urandom_range(0, 300)) : 16'($urandom)),
                                 ($urandom_range(0, 3) ? 5'($urandom_range(0, 8)) : 5'($urandom)),
                                 8'($urandom)));
      else if (r < 95)
        op_queue.push_back(mk_op(MODE_READ, 2'($urandom),
                                 ($urandom_range(0, 4) ? 16'($urandom_range(0, 120)) : 16'($urandom)),
                                 16'($urandom_range(0, 160)), 5'($urandom), 8'($urandom)));
      else
        op_queue.push_back(mk_op(3'($urandom_range(5, 7)), 2'($urandom), 16'($urandom),
                                 16'($urandom), 5'($urandom), 8'($urandom)));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (op_queue.size() == 0 && !in_valid_i);
    wait (piece_queue.size() == 0);
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && piece_queue.size() == 0) begin
      $display("tb_segment_gather_table_top: clean");
    end else begin
      $display("tb_segment_gather_table_top: errors");
    end
    $finish;
  end

endmodule
